### hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round functions of the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [3:0] word4_t;

    localparam word_t IV_A = 32'h67452301;
    localparam word_t IV_B = 32'hefcdab89;
    localparam word_t IV_C = 32'h98badcfe;
    localparam word_t IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS  = 6'd55;

    localparam word_t K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_FIN
    } st_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_FIN
    } ret_t;

    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } buf_wr_t;

    typedef struct packed {
        logic       done;
        logic [3:0] msg_idx;
    } rnd_sts_t;

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [7:0] w;
        logic [7:0] g1;
        logic [7:0] g2;
        logic [7:0] g3;
        logic [3:0] g;
        w  = {2'b00, i};
        g1 = w * 8'd5 + 8'd1;
        g2 = w * 8'd3 + 8'd5;
        g3 = w * 8'd7;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = g1[3:0];
            2'd2: g = g2[3:0];
            2'd3: g = g3[3:0];
        endcase
        return g;
    endfunction

    function automatic word_t round_f(input logic [1:0] grp, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        unique case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

### hdl/md5_buf.sv
// ----------------------------------------------------------------------------
// md5_buf
// 64-byte block buffer: byte-wide write, 32-bit little-endian word read.
// ----------------------------------------------------------------------------
module md5_buf (
    input  logic                 aclk,
    input  md5_pkg::buf_wr_t     wr,
    input  logic [3:0]           rd_idx,
    output md5_pkg::word_t       rd_word
);
    import md5_pkg::*;

    word_t words_mem [16];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            words_mem[wr.addr[5:2]][{wr.addr[1:0], 3'b000} +: 8] <= wr.data;
        end
    end

    assign rd_word = words_mem[rd_idx];

endmodule

### hdl/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// Shared MD5 round unit: runs 64 rounds, each as a sum phase and an update phase.
// ----------------------------------------------------------------------------
module md5_round (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  md5_pkg::word4_t      chain,
    input  md5_pkg::word_t       msg_word,
    output md5_pkg::rnd_sts_t    sts,
    output md5_pkg::word4_t      words
);
    import md5_pkg::*;

    logic [5:0] rnd_reg,   rnd_next;
    logic       phase_reg, phase_next;
    logic       busy_reg,  busy_next;
    logic       done_reg,  done_next;
    word4_t     words_reg, words_next;
    word_t      t_reg,     t_next;
    word_t      f;
    logic [63:0] rot_wide;
    logic [4:0] rot_amt;

    assign f        = round_f(rnd_reg[5:4], words_reg[1], words_reg[2], words_reg[3]);
    assign rot_amt  = ROT_TAB[{rnd_reg[5:4], rnd_reg[1:0]}];
    assign rot_wide = {t_reg, t_reg} << rot_amt;

    always_comb begin
        rnd_next   = rnd_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        words_next = words_reg;
        t_next     = t_reg;
        if (start) begin
            words_next = chain;
            rnd_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                t_next     = words_reg[0] + f + K_TAB[rnd_reg] + msg_word;
                phase_next = 1'b1;
            end else begin
                words_next[0] = words_reg[3];
                words_next[1] = words_reg[1] + rot_wide[63:32];
                words_next[2] = words_reg[1];
                words_next[3] = words_reg[2];
                phase_next    = 1'b0;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == LAST_POS) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_reg   <= '0;
            phase_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            rnd_reg   <= rnd_next;
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
        words_reg <= words_next;
        t_reg     <= t_next;
    end

    assign sts.done    = done_reg;
    assign sts.msg_idx = msg_index(rnd_reg);
    assign words       = words_reg;

endmodule

### hdl/md5_message_digest.sv
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one byte per request, digest on tlast.
// ----------------------------------------------------------------------------
// A byte request is taken whenever the block is idle. A byte that completes
// a 64-byte block also runs the compression, which holds s_tready low while
// one shared round unit runs 64 rounds and while the result is folded into
// the chaining words. A request with tlast then writes the padding one byte
// per cycle up to the end of the block and compresses once more, or twice
// when no more than 8 bytes of the block remain. The digest appears on
// m_tdata in an output register; the next message may start while it waits,
// and the block stalls only if a new digest is ready before the previous one
// is taken.
module md5_message_digest (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] msg_byte
    input  logic         s_tuser,   // [0] byte_present
    input  logic         s_tlast,   // is_last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [31:0] digest_a, [63:32] digest_b,
                                    // [95:64] digest_c, [127:96] digest_d
);
    import md5_pkg::*;

    st_t          state_reg, state_next;
    ret_t         ret_reg, ret_next;
    logic [60:0]  cnt_reg;
    logic [5:0]   pad_ptr_reg;
    logic         first_reg;
    word4_t       chain_reg;
    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;

    logic         s_acc;
    logic         out_go;
    logic         rnd_start;
    buf_wr_t      buf_wr;
    rnd_sts_t     rnd_sts;
    word_t        msg_word;
    word4_t       rnd_words;
    logic [63:0]  bit_len;
    logic [7:0]   len_byte;

    md5_buf u_buf (
        .aclk    (aclk),
        .wr      (buf_wr),
        .rd_idx  (rnd_sts.msg_idx),
        .rd_word (msg_word)
    );

    md5_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rnd_start),
        .chain    (chain_reg),
        .msg_word (msg_word),
        .sts      (rnd_sts),
        .words    (rnd_words)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_go   = !m_tvalid_reg || m_tready;
    assign bit_len  = {cnt_reg, 3'b000};
    assign len_byte = bit_len[{pad_ptr_reg[2:0], 3'b000} +: 8];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser && cnt_reg[5:0] == LAST_POS) begin
                        state_next = ST_COMP;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (rnd_sts.done) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                unique case (ret_reg)
                    RET_PAD: state_next = ST_PAD;
                    RET_FIN: state_next = ST_FIN;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_PAD: begin
                if (pad_ptr_reg == LAST_POS) begin
                    state_next = ST_COMP;
                end else if (pad_ptr_reg == LEN_POS) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (pad_ptr_reg == LAST_POS) begin
                    state_next = ST_COMP;
                end
            end
            ST_FIN: begin
                if (out_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        buf_wr    = '0;
        rnd_start = 1'b0;
        ret_next  = ret_reg;
        unique case (state_reg)
            ST_IDLE: begin
                buf_wr.en   = s_acc && s_tuser;
                buf_wr.addr = cnt_reg[5:0];
                buf_wr.data = s_tdata;
                rnd_start   = s_acc && s_tuser && cnt_reg[5:0] == LAST_POS;
                ret_next    = s_tlast ? RET_PAD : RET_IDLE;
            end
            ST_PAD: begin
                buf_wr.en   = 1'b1;
                buf_wr.addr = pad_ptr_reg;
                buf_wr.data = first_reg ? PAD_BYTE : 8'h00;
                rnd_start   = (pad_ptr_reg == LAST_POS);
                ret_next    = RET_PAD;
            end
            ST_LEN: begin
                buf_wr.en   = 1'b1;
                buf_wr.addr = pad_ptr_reg;
                buf_wr.data = len_byte;
                rnd_start   = (pad_ptr_reg == LAST_POS);
                ret_next    = RET_FIN;
            end
            default: begin
                buf_wr    = '0;
                rnd_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= RET_IDLE;
            cnt_reg      <= '0;
            pad_ptr_reg  <= '0;
            first_reg    <= 1'b0;
            chain_reg    <= {IV_D, IV_C, IV_B, IV_A};
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (rnd_start) begin
                ret_reg <= ret_next;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_tuser) begin
                        cnt_reg <= cnt_reg + 61'd1;
                    end
                    if (s_acc && s_tlast) begin
                        pad_ptr_reg <= s_tuser ? cnt_reg[5:0] + 6'd1 : cnt_reg[5:0];
                        first_reg   <= 1'b1;
                    end
                end
                ST_ADD: begin
                    chain_reg[0] <= chain_reg[0] + rnd_words[0];
                    chain_reg[1] <= chain_reg[1] + rnd_words[1];
                    chain_reg[2] <= chain_reg[2] + rnd_words[2];
                    chain_reg[3] <= chain_reg[3] + rnd_words[3];
                end
                ST_PAD, ST_LEN: begin
                    pad_ptr_reg <= pad_ptr_reg + 6'd1;
                    first_reg   <= 1'b0;
                end
                ST_FIN: begin
                    if (out_go) begin
                        chain_reg <= {IV_D, IV_C, IV_B, IV_A};
                        cnt_reg   <= '0;
                    end
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            if (state_reg == ST_FIN && out_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (state_reg == ST_FIN && out_go) begin
            m_tdata_reg <= chain_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_done_in_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_sts.done |-> state_reg == ST_COMP)
        else $error("round unit finished outside compression");

    a_start_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_start |-> state_reg != ST_COMP && state_reg != ST_ADD)
        else $error("round unit restarted during compression");

    a_digest_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FIN)
        else $error("digest presented without finishing a message");

    a_len_position: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LEN |-> pad_ptr_reg[5:3] == 3'b111)
        else $error("length bytes written outside the block tail");
`endif

endmodule
